// ===== rtl/esc_pkg.sv =====
package esc_pkg;

    // Geometry and field widths.
    localparam int HEIGHT_BITS  = 20;
    localparam int MAX_COLS     = 1024;
    localparam int MAX_ROWS     = 1024;
    localparam int COL_W        = $clog2(MAX_COLS);
    localparam int ROW_W        = $clog2(MAX_ROWS);
    localparam int GEOM_W       = 11;
    localparam int INV_W        = 16;
    localparam int ANG_W        = 15;
    localparam int CLS_W        = 3;
    localparam int CELL_W       = HEIGHT_BITS + 1;

    // Arithmetic widths.
    localparam int SUM_W        = HEIGHT_BITS + 3;
    localparam int MAG_W        = SUM_W - 1;
    localparam int GRAD_W       = 31;
    localparam int MUL_W        = 32;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int ROOT_STEPS   = PROD_W / 2;
    localparam int ROOT_W       = PROD_W / 2;
    localparam int ITER_W       = $clog2(ROOT_STEPS);
    localparam int CORDIC_STEPS = 18;
    localparam int CX_W         = 51;
    localparam int Z_W          = 25;
    localparam int ANGLE_MAX    = 23040;

    // Configuration port.
    localparam int APB_ADDR_W   = 5;
    localparam int APB_DATA_W   = 32;
    localparam int REG_IDX_W    = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_MAP_COLS = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAP_ROWS = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INV_CELL = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BOUND_1  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BOUND_2  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BOUND_3  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BOUND_4  = 3'd6;

    typedef struct packed {
        logic                          ok;
        logic signed [HEIGHT_BITS-1:0] h;
    } t_cell;

    typedef struct packed {
        logic signed [HEIGHT_BITS-1:0] height_mm;
        logic                          height_ok;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0] cell_row;
        logic [COL_W-1:0] cell_col;
        logic [ANG_W-1:0] slope_angle;
        logic             slope_ok;
        logic [CLS_W-1:0] slope_class;
        logic             map_done;
    } t_out_item;

    typedef struct packed {
        logic [GEOM_W-1:0] map_cols;
        logic [GEOM_W-1:0] map_rows;
        logic [INV_W-1:0]  inv_cell_q16;
        logic [ANG_W-1:0]  class_bound_1;
        logic [ANG_W-1:0]  class_bound_2;
        logic [ANG_W-1:0]  class_bound_3;
        logic [ANG_W-1:0]  class_bound_4;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_NEAR, S_RD_EAST, S_SELECT, S_LOAD, S_GRAD_X, S_GRAD_Y,
        S_SQ_X, S_SQ_Y, S_SUM, S_ROOT, S_ROT_INIT, S_ROTATE, S_FINISH,
        S_EMIT, S_UPDATE
    } t_state;

    // Which reported cell is being worked on for the current transaction.
    typedef enum logic [1:0] {
        KIND_UPPER, KIND_WEST, KIND_LAST, KIND_END
    } t_kind;

    typedef struct packed {
        logic              accept;
        logic              cap_near;
        logic              cap_east;
        logic              load;
        logic              grad_x;
        logic              grad_y;
        logic              sq_x;
        logic              sq_y;
        logic              sum;
        logic              root;
        logic              rot_init;
        logic              rotate;
        logic              finish;
        logic              emit;
        logic              update;
        t_kind             kind;
        logic [ITER_W-1:0] iter;
    } t_cmd;

    typedef struct packed {
        logic need_upper;
        logic need_west;
        logic need_last;
        logic out_free;
    } t_status;

    // Arctangent of 2^-i in 2^-16 degree.
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 25'sd2949120;
            5'd1:    v = 25'sd1740967;
            5'd2:    v = 25'sd919879;
            5'd3:    v = 25'sd466945;
            5'd4:    v = 25'sd234379;
            5'd5:    v = 25'sd117304;
            5'd6:    v = 25'sd58666;
            5'd7:    v = 25'sd29335;
            5'd8:    v = 25'sd14668;
            5'd9:    v = 25'sd7334;
            5'd10:   v = 25'sd3667;
            5'd11:   v = 25'sd1833;
            5'd12:   v = 25'sd917;
            5'd13:   v = 25'sd458;
            5'd14:   v = 25'sd229;
            5'd15:   v = 25'sd115;
            5'd16:   v = 25'sd57;
            5'd17:   v = 25'sd29;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/esc_ram.sv =====
module esc_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/esc_ctrl.sv =====
module esc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  esc_pkg::t_status i_status,
    output esc_pkg::t_cmd   o_cmd,
    output logic            o_in_stall
);

    esc_pkg::t_state             r_state, n_state;
    esc_pkg::t_kind              r_kind, n_kind;
    logic [esc_pkg::ITER_W-1:0]  r_iter, n_iter;
    logic                        need;
    logic                        root_last;
    logic                        rot_last;

    function automatic esc_pkg::t_kind kind_after(input esc_pkg::t_kind k);
        esc_pkg::t_kind v;
        case (k)
            esc_pkg::KIND_UPPER: v = esc_pkg::KIND_WEST;
            esc_pkg::KIND_WEST:  v = esc_pkg::KIND_LAST;
            default:             v = esc_pkg::KIND_END;
        endcase
        return v;
    endfunction

    // Whether the current candidate cell produces a result.
    always_comb begin
        case (r_kind)
            esc_pkg::KIND_UPPER: need = i_status.need_upper;
            esc_pkg::KIND_WEST:  need = i_status.need_west;
            esc_pkg::KIND_LAST:  need = i_status.need_last;
            default:             need = 1'b0;
        endcase
    end

    assign root_last = (r_iter == esc_pkg::ITER_W'(esc_pkg::ROOT_STEPS - 1));
    assign rot_last  = (r_iter == esc_pkg::ITER_W'(esc_pkg::CORDIC_STEPS - 1));

    // Next state, candidate and iteration count.
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_iter  = r_iter;
        case (r_state)
            esc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = esc_pkg::S_RD_NEAR;
                    n_kind  = esc_pkg::KIND_UPPER;
                end
            end
            esc_pkg::S_RD_NEAR: n_state = esc_pkg::S_RD_EAST;
            esc_pkg::S_RD_EAST: n_state = esc_pkg::S_SELECT;
            esc_pkg::S_SELECT: begin
                if (r_kind == esc_pkg::KIND_END) begin
                    n_state = esc_pkg::S_UPDATE;
                end else if (need) begin
                    n_state = esc_pkg::S_LOAD;
                end else begin
                    n_kind = kind_after(r_kind);
                end
            end
            esc_pkg::S_LOAD:   n_state = esc_pkg::S_GRAD_X;
            esc_pkg::S_GRAD_X: n_state = esc_pkg::S_GRAD_Y;
            esc_pkg::S_GRAD_Y: n_state = esc_pkg::S_SQ_X;
            esc_pkg::S_SQ_X:   n_state = esc_pkg::S_SQ_Y;
            esc_pkg::S_SQ_Y:   n_state = esc_pkg::S_SUM;
            esc_pkg::S_SUM: begin
                n_state = esc_pkg::S_ROOT;
                n_iter  = '0;
            end
            esc_pkg::S_ROOT: begin
                n_iter = r_iter + esc_pkg::ITER_W'(1);
                if (root_last) begin
                    n_state = esc_pkg::S_ROT_INIT;
                end
            end
            esc_pkg::S_ROT_INIT: begin
                n_state = esc_pkg::S_ROTATE;
                n_iter  = '0;
            end
            esc_pkg::S_ROTATE: begin
                n_iter = r_iter + esc_pkg::ITER_W'(1);
                if (rot_last) begin
                    n_state = esc_pkg::S_FINISH;
                end
            end
            esc_pkg::S_FINISH: n_state = esc_pkg::S_EMIT;
            esc_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = esc_pkg::S_SELECT;
                    n_kind  = kind_after(r_kind);
                end
            end
            esc_pkg::S_UPDATE: n_state = esc_pkg::S_IDLE;
            default:           n_state = esc_pkg::S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd          = '0;
        o_cmd.kind     = r_kind;
        o_cmd.iter     = r_iter;
        o_cmd.accept   = (r_state == esc_pkg::S_IDLE) && i_in_valid;
        o_cmd.cap_near = (r_state == esc_pkg::S_RD_NEAR);
        o_cmd.cap_east = (r_state == esc_pkg::S_RD_EAST);
        o_cmd.load     = (r_state == esc_pkg::S_LOAD);
        o_cmd.grad_x   = (r_state == esc_pkg::S_GRAD_X);
        o_cmd.grad_y   = (r_state == esc_pkg::S_GRAD_Y);
        o_cmd.sq_x     = (r_state == esc_pkg::S_SQ_X);
        o_cmd.sq_y     = (r_state == esc_pkg::S_SQ_Y);
        o_cmd.sum      = (r_state == esc_pkg::S_SUM);
        o_cmd.root     = (r_state == esc_pkg::S_ROOT);
        o_cmd.rot_init = (r_state == esc_pkg::S_ROT_INIT);
        o_cmd.rotate   = (r_state == esc_pkg::S_ROTATE);
        o_cmd.finish   = (r_state == esc_pkg::S_FINISH);
        o_cmd.emit     = (r_state == esc_pkg::S_EMIT) && i_status.out_free;
        o_cmd.update   = (r_state == esc_pkg::S_UPDATE);
    end

    assign o_in_stall = (r_state != esc_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= esc_pkg::S_IDLE;
            r_kind  <= esc_pkg::KIND_UPPER;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_iter  <= n_iter;
        end
    end

endmodule

// ===== rtl/esc_dp.sv =====
module esc_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  esc_pkg::t_cmd      i_cmd,
    input  esc_pkg::t_cfg      i_cfg,
    input  logic               i_cfg_restart,
    input  esc_pkg::t_in_item  i_in_data,
    input  logic               i_out_stall,
    output esc_pkg::t_status   o_status,
    output logic               o_out_valid,
    output esc_pkg::t_out_item o_out_data
);

    localparam logic signed [esc_pkg::CX_W-1:0] X_START =
        esc_pkg::CX_W'(64'h1_0000_0000);

    // Map position and neighbourhood of the current transaction.
    logic [esc_pkg::ROW_W-1:0]  r_row;
    logic [esc_pkg::COL_W-1:0]  r_col;
    esc_pkg::t_cell             r_cur, r_old_lo, r_old_up, r_east;
    esc_pkg::t_cell             r_lo_west, r_w1, r_w2;

    // Per-result working registers.
    logic signed [esc_pkg::SUM_W-1:0] r_sum_x, r_sum_y;
    logic                             r_two_x, r_two_y;
    logic                             r_ctr_ok;
    logic [esc_pkg::ROW_W-1:0]        r_pos_row;
    logic [esc_pkg::COL_W-1:0]        r_pos_col;
    logic                             r_done;
    logic [esc_pkg::GRAD_W-1:0]       r_gx, r_gy;
    logic [esc_pkg::PROD_W-1:0]       r_sq_x, r_sq_y;
    logic [esc_pkg::PROD_W-1:0]       r_rem, r_root;
    logic signed [esc_pkg::CX_W-1:0]  r_cx, r_cy;
    logic signed [esc_pkg::Z_W-1:0]   r_cz;
    esc_pkg::t_out_item               r_res;
    logic                             r_out_valid;
    esc_pkg::t_out_item               r_out;

    logic [esc_pkg::GEOM_W-1:0] col_next, row_next;
    logic                       last_col, last_row, east_pos_ok;
    logic [esc_pkg::COL_W-1:0]  lo_raddr;
    logic [esc_pkg::CELL_W-1:0] lo_rdata, up_rdata;

    esc_pkg::t_cell             c_ctr, c_n, c_s, c_w, c_e;
    logic [esc_pkg::ROW_W-1:0]  sel_row;
    logic [esc_pkg::COL_W-1:0]  sel_col;
    logic                       sel_done;
    logic signed [esc_pkg::SUM_W-1:0] sum_x, sum_y;

    logic signed [esc_pkg::SUM_W-1:0] grad_sum;
    logic [esc_pkg::SUM_W-1:0]  grad_abs;
    logic                       grad_two;
    logic [esc_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic [esc_pkg::PROD_W-1:0] prod, halved;
    logic [esc_pkg::GRAD_W-1:0] grad_val;

    logic [5:0]                 root_sh;
    logic [esc_pkg::PROD_W-1:0] root_bit, root_trial;

    logic signed [esc_pkg::CX_W-1:0] sh_x, sh_y;
    logic signed [esc_pkg::Z_W-1:0]  z_rnd;
    logic [esc_pkg::ANG_W-1:0]       angle;
    logic [esc_pkg::CLS_W-1:0]       cls;

    function automatic logic signed [esc_pkg::SUM_W-1:0] ext_h(input esc_pkg::t_cell c);
        return signed'({{(esc_pkg::SUM_W - esc_pkg::HEIGHT_BITS){c.h[esc_pkg::HEIGHT_BITS-1]}},
                        c.h});
    endfunction

    // Arithmetic shift right that truncates toward zero.
    function automatic logic signed [esc_pkg::CX_W-1:0] shr_tz(
        input logic signed [esc_pkg::CX_W-1:0] v,
        input logic [esc_pkg::ITER_W-1:0]      s
    );
        logic [esc_pkg::CX_W-1:0] mag;
        logic [esc_pkg::CX_W-1:0] sh;
        mag = v[esc_pkg::CX_W-1] ? unsigned'(-v) : unsigned'(v);
        sh  = mag >> s;
        return v[esc_pkg::CX_W-1] ? -signed'(sh) : signed'(sh);
    endfunction

    // Position flags.
    assign col_next    = esc_pkg::GEOM_W'(r_col) + esc_pkg::GEOM_W'(1);
    assign row_next    = esc_pkg::GEOM_W'(r_row) + esc_pkg::GEOM_W'(1);
    assign last_col    = (col_next >= i_cfg.map_cols);
    assign last_row    = (row_next >= i_cfg.map_rows);
    assign east_pos_ok = !last_col && (r_col != esc_pkg::COL_W'(esc_pkg::MAX_COLS - 1));

    assign o_status.need_upper = (r_row != '0);
    assign o_status.need_west  = last_row && (r_col != '0);
    assign o_status.need_last  = last_row && last_col;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    // Line stores: the lower one is read at the column and then at the east neighbour.
    assign lo_raddr = i_cmd.cap_near ? r_col + esc_pkg::COL_W'(1) : r_col;

    esc_ram #(.WIDTH(esc_pkg::CELL_W), .DEPTH(esc_pkg::MAX_COLS)) u_lo_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_waddr (r_col),
        .i_wdata (r_cur),
        .i_raddr (lo_raddr),
        .o_rdata (lo_rdata)
    );

    esc_ram #(.WIDTH(esc_pkg::CELL_W), .DEPTH(esc_pkg::MAX_COLS)) u_up_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_waddr (r_col),
        .i_wdata (r_old_lo),
        .i_raddr (r_col),
        .o_rdata (up_rdata)
    );

    // Neighbour selection for the cell being reported.
    always_comb begin
        c_s      = '0;
        c_e      = '0;
        sel_done = 1'b0;
        case (i_cmd.kind)
            esc_pkg::KIND_UPPER: begin
                c_ctr   = r_old_lo;
                c_n     = (r_row > esc_pkg::ROW_W'(1)) ? r_old_up : '0;
                c_s     = r_cur;
                c_w     = (r_col != '0) ? r_lo_west : '0;
                c_e     = r_east;
                sel_row = r_row - esc_pkg::ROW_W'(1);
                sel_col = r_col;
            end
            esc_pkg::KIND_WEST: begin
                c_ctr   = r_w1;
                c_n     = (r_row != '0) ? r_lo_west : '0;
                c_w     = (r_col > esc_pkg::COL_W'(1)) ? r_w2 : '0;
                c_e     = r_cur;
                sel_row = r_row;
                sel_col = r_col - esc_pkg::COL_W'(1);
            end
            default: begin
                c_ctr    = r_cur;
                c_n      = (r_row != '0) ? r_old_lo : '0;
                c_w      = (r_col != '0) ? r_w1 : '0;
                sel_row  = r_row;
                sel_col  = r_col;
                sel_done = 1'b1;
            end
        endcase
        sum_x = (c_w.ok ? ext_h(c_ctr) - ext_h(c_w) : '0)
              + (c_e.ok ? ext_h(c_e) - ext_h(c_ctr) : '0);
        sum_y = (c_n.ok ? ext_h(c_ctr) - ext_h(c_n) : '0)
              + (c_s.ok ? ext_h(c_s) - ext_h(c_ctr) : '0);
    end

    // Shared multiplier: gradient scaling, then squaring.
    always_comb begin
        grad_sum = i_cmd.grad_x ? r_sum_x : r_sum_y;
        grad_two = i_cmd.grad_x ? r_two_x : r_two_y;
        grad_abs = grad_sum[esc_pkg::SUM_W-1] ? unsigned'(-grad_sum) : unsigned'(grad_sum);
        if (i_cmd.grad_x || i_cmd.grad_y) begin
            mul_a = esc_pkg::MUL_W'(grad_abs[esc_pkg::MAG_W-1:0]);
            mul_b = esc_pkg::MUL_W'(i_cfg.inv_cell_q16);
        end else if (i_cmd.sq_x) begin
            mul_a = esc_pkg::MUL_W'(r_gx);
            mul_b = esc_pkg::MUL_W'(r_gx);
        end else begin
            mul_a = esc_pkg::MUL_W'(r_gy);
            mul_b = esc_pkg::MUL_W'(r_gy);
        end
        prod     = mul_a * mul_b;
        halved   = grad_two ? (prod >> 1) : prod;
        grad_val = (|halved[esc_pkg::PROD_W-1:esc_pkg::GRAD_W]) ? '1
                                                              : halved[esc_pkg::GRAD_W-1:0];
    end

    // One digit of the integer square root per cycle.
    assign root_sh    = 6'(esc_pkg::PROD_W - 2) - {i_cmd.iter, 1'b0};
    assign root_bit   = esc_pkg::PROD_W'(1) << root_sh;
    assign root_trial = r_root + root_bit;

    // One CORDIC vectoring step per cycle.
    assign sh_x = shr_tz(r_cx, i_cmd.iter);
    assign sh_y = shr_tz(r_cy, i_cmd.iter);

    // Rounding, clamping and classification of the angle.
    always_comb begin
        z_rnd = (r_cz + esc_pkg::Z_W'(128)) >>> 8;
        if (!r_ctr_ok || (r_root == '0) || r_cz[esc_pkg::Z_W-1]) begin
            angle = '0;
        end else if (z_rnd > esc_pkg::Z_W'(esc_pkg::ANGLE_MAX)) begin
            angle = esc_pkg::ANG_W'(esc_pkg::ANGLE_MAX);
        end else begin
            angle = z_rnd[esc_pkg::ANG_W-1:0];
        end
        if (!r_ctr_ok) begin
            cls = 3'd0;
        end else if (angle < i_cfg.class_bound_1) begin
            cls = 3'd0;
        end else if (angle < i_cfg.class_bound_2) begin
            cls = 3'd1;
        end else if (angle < i_cfg.class_bound_3) begin
            cls = 3'd2;
        end else if (angle < i_cfg.class_bound_4) begin
            cls = 3'd3;
        end else begin
            cls = 3'd4;
        end
    end

    // Position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_restart) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.update) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + esc_pkg::ROW_W'(1);
            end else begin
                r_col <= r_col + esc_pkg::COL_W'(1);
            end
        end
    end

    // Neighbourhood capture at the start and shift at the end of a transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur.h  <= i_in_data.height_mm;
            r_cur.ok <= i_in_data.height_ok;
        end
        if (i_cmd.cap_near) begin
            r_old_lo <= esc_pkg::t_cell'(lo_rdata);
            r_old_up <= esc_pkg::t_cell'(up_rdata);
        end
        if (i_cmd.cap_east) begin
            r_east <= east_pos_ok ? esc_pkg::t_cell'(lo_rdata) : '0;
        end
        if (i_cmd.update) begin
            r_lo_west <= r_old_lo;
            r_w2      <= r_w1;
            r_w1      <= r_cur;
        end
    end

    // Gradient, square root and CORDIC datapath.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sum_x   <= sum_x;
            r_sum_y   <= sum_y;
            r_two_x   <= c_w.ok && c_e.ok;
            r_two_y   <= c_n.ok && c_s.ok;
            r_ctr_ok  <= c_ctr.ok;
            r_pos_row <= sel_row;
            r_pos_col <= sel_col;
            r_done    <= sel_done;
        end
        if (i_cmd.grad_x) begin
            r_gx <= grad_val;
        end
        if (i_cmd.grad_y) begin
            r_gy <= grad_val;
        end
        if (i_cmd.sq_x) begin
            r_sq_x <= prod;
        end
        if (i_cmd.sq_y) begin
            r_sq_y <= prod;
        end
        if (i_cmd.sum) begin
            r_rem  <= r_sq_x + r_sq_y;
            r_root <= '0;
        end
        if (i_cmd.root) begin
            if (r_rem >= root_trial) begin
                r_rem  <= r_rem - root_trial;
                r_root <= (r_root >> 1) + root_bit;
            end else begin
                r_root <= r_root >> 1;
            end
        end
        if (i_cmd.rot_init) begin
            r_cx <= X_START;
            r_cy <= esc_pkg::CX_W'({r_root[esc_pkg::ROOT_W-1:0], 16'h0000});
            r_cz <= '0;
        end
        if (i_cmd.rotate) begin
            if (!r_cy[esc_pkg::CX_W-1]) begin
                r_cx <= r_cx + sh_y;
                r_cy <= r_cy - sh_x;
                r_cz <= r_cz + esc_pkg::atan_entry(i_cmd.iter);
            end else begin
                r_cx <= r_cx - sh_y;
                r_cy <= r_cy + sh_x;
                r_cz <= r_cz - esc_pkg::atan_entry(i_cmd.iter);
            end
        end
        if (i_cmd.finish) begin
            r_res.cell_row    <= r_pos_row;
            r_res.cell_col    <= r_pos_col;
            r_res.slope_angle <= angle;
            r_res.slope_ok    <= r_ctr_ok;
            r_res.slope_class <= cls;
            r_res.map_done    <= r_done;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/elevation_slope_classifier.sv =====
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_in_data  (esc_pkg::t_in_item)
// output    out        o_out_valid / i_out_stall  o_out_data (esc_pkg::t_out_item)
// config    in         APB psel/penable/pwrite    paddr, pwdata, prdata
//
// One transaction at a time: the accept, two line store reads, four candidate checks and the
// update, plus for each of its 0 to 3 results a 32-step square root and an 18-step CORDIC,
// plus any time that a result waits for the output register to free up.
// Reset is synchronous and active low; line stores are not cleared.
// A result waits in the output register while the block takes the next transaction.
// Writing map_cols or map_rows restarts the map at row 0, column 0.
module elevation_slope_classifier (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  esc_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output esc_pkg::t_out_item                o_out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [esc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [esc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [esc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    esc_pkg::t_cfg                  r_cfg;
    esc_pkg::t_cmd                  cmd;
    esc_pkg::t_status               status;
    logic                           cfg_wr;
    logic                           cfg_restart;
    logic [esc_pkg::REG_IDX_W-1:0]  cfg_idx;
    logic [esc_pkg::GEOM_W-1:0]     geom_raw, cols_sat, rows_sat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[esc_pkg::APB_ADDR_W-1:2];

    // Geometry writes are saturated to the supported range.
    always_comb begin
        geom_raw = pwdata[esc_pkg::GEOM_W-1:0];
        if (geom_raw == '0) begin
            cols_sat = esc_pkg::GEOM_W'(1);
            rows_sat = esc_pkg::GEOM_W'(1);
        end else begin
            cols_sat = (geom_raw > esc_pkg::GEOM_W'(esc_pkg::MAX_COLS))
                     ? esc_pkg::GEOM_W'(esc_pkg::MAX_COLS) : geom_raw;
            rows_sat = (geom_raw > esc_pkg::GEOM_W'(esc_pkg::MAX_ROWS))
                     ? esc_pkg::GEOM_W'(esc_pkg::MAX_ROWS) : geom_raw;
        end
    end

    assign cfg_restart = cfg_wr && ((cfg_idx == esc_pkg::REG_MAP_COLS) ||
                                    (cfg_idx == esc_pkg::REG_MAP_ROWS));

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_cols      <= esc_pkg::GEOM_W'(esc_pkg::MAX_COLS);
            r_cfg.map_rows      <= esc_pkg::GEOM_W'(esc_pkg::MAX_ROWS);
            r_cfg.inv_cell_q16  <= esc_pkg::INV_W'(655);
            r_cfg.class_bound_1 <= esc_pkg::ANG_W'(2560);
            r_cfg.class_bound_2 <= esc_pkg::ANG_W'(3840);
            r_cfg.class_bound_3 <= esc_pkg::ANG_W'(5120);
            r_cfg.class_bound_4 <= esc_pkg::ANG_W'(6400);
        end else if (cfg_wr) begin
            case (cfg_idx)
                esc_pkg::REG_MAP_COLS: r_cfg.map_cols      <= cols_sat;
                esc_pkg::REG_MAP_ROWS: r_cfg.map_rows      <= rows_sat;
                esc_pkg::REG_INV_CELL: r_cfg.inv_cell_q16  <= pwdata[esc_pkg::INV_W-1:0];
                esc_pkg::REG_BOUND_1:  r_cfg.class_bound_1 <= pwdata[esc_pkg::ANG_W-1:0];
                esc_pkg::REG_BOUND_2:  r_cfg.class_bound_2 <= pwdata[esc_pkg::ANG_W-1:0];
                esc_pkg::REG_BOUND_3:  r_cfg.class_bound_3 <= pwdata[esc_pkg::ANG_W-1:0];
                esc_pkg::REG_BOUND_4:  r_cfg.class_bound_4 <= pwdata[esc_pkg::ANG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (cfg_idx)
            esc_pkg::REG_MAP_COLS: prdata = esc_pkg::APB_DATA_W'(r_cfg.map_cols);
            esc_pkg::REG_MAP_ROWS: prdata = esc_pkg::APB_DATA_W'(r_cfg.map_rows);
            esc_pkg::REG_INV_CELL: prdata = esc_pkg::APB_DATA_W'(r_cfg.inv_cell_q16);
            esc_pkg::REG_BOUND_1:  prdata = esc_pkg::APB_DATA_W'(r_cfg.class_bound_1);
            esc_pkg::REG_BOUND_2:  prdata = esc_pkg::APB_DATA_W'(r_cfg.class_bound_2);
            esc_pkg::REG_BOUND_3:  prdata = esc_pkg::APB_DATA_W'(r_cfg.class_bound_3);
            esc_pkg::REG_BOUND_4:  prdata = esc_pkg::APB_DATA_W'(r_cfg.class_bound_4);
            default:               prdata = '0;
        endcase
    end

    esc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    esc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg         (r_cfg),
        .i_cfg_restart (cfg_restart),
        .i_in_data     (i_in_data),
        .i_out_stall   (i_out_stall),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

endmodule

// ===== rtl/esc_chk.sv =====
module esc_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input esc_pkg::t_out_item o_out_data,
    input logic               pready
);

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // The block works on one transaction at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");

    // A cell without a valid centre reports a zero angle and class.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.slope_ok |->
            (o_out_data.slope_angle == '0) && (o_out_data.slope_class == '0))
        else $error("invalid cell with nonzero slope");

    // Angle and class stay in range.
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.slope_class <= 3'd4) &&
                        (o_out_data.slope_angle <= 15'd23040))
        else $error("result out of range");

    // The configuration port never waits.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind elevation_slope_classifier esc_chk u_esc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .pready      (pready)
);
